FILE: rtl/asc_pkg.sv
// shared types and constants for the allocator size class mapper
package asc_pkg;

  localparam int SIZE_W        = 40;
  localparam int CSIZE_W       = 41;
  localparam int CIDX_W        = 37;
  localparam int ALIGN_W       = 21;
  localparam int CNT_W         = 7;
  localparam int TOK_IDX_W     = 10;
  localparam int DEFAULT_DEPTH = 64;
  localparam int APB_DW        = 64;
  localparam int APB_AW        = 6;
  localparam int SLOT_W        = 6;

  localparam logic [1:0] CAT_SMALL  = 2'd0;
  localparam logic [1:0] CAT_MEDIUM = 2'd1;
  localparam logic [1:0] CAT_LARGE  = 2'd2;

  localparam logic [2:0] REG_TABLE_MODE  = 3'd0;
  localparam logic [2:0] REG_MIDDLE_THR  = 3'd1;
  localparam logic [2:0] REG_LARGE_THR   = 3'd2;
  localparam logic [2:0] REG_LARGE_ALIGN = 3'd3;
  localparam logic [2:0] REG_CLASS_COUNT = 3'd4;

  localparam logic OP_LOOKUP = 1'b0;
  localparam logic OP_WRITE  = 1'b1;

  localparam logic [SIZE_W-1:0]  LARGE_THR_RST = '1;
  localparam logic [ALIGN_W-1:0] ALIGN_RST     = 21'd4096;

  localparam logic [SIZE_W-1:0] FORMULA_BASE = 40'd24;
  localparam int                FORMULA_SH   = 4;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHAIN,
    S_DIV,
    S_DONE
  } asc_state_t;

  // search token handed from cell to cell
  typedef struct packed {
    logic                 valid;
    logic                 hit;
    logic [SIZE_W-1:0]    csize;
    logic [TOK_IDX_W-1:0] idx;
  } asc_tok_t;

endpackage

FILE: rtl/asc_cell.sv
// one table entry plus one stage of the search chain
module asc_cell import asc_pkg::*; #(
  parameter int CELL_ID = 0
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              we,
  input  logic [SIZE_W-1:0] wdata,
  input  logic [SIZE_W-1:0] size,
  input  logic [CNT_W-1:0]  class_count,
  input  asc_tok_t          tok_in,
  output asc_tok_t          tok_out
);

  localparam int IDW = TOK_IDX_W + 1;
  localparam logic [IDW-1:0] MY_ID = IDW'(CELL_ID);

  logic [SIZE_W-1:0] entry_r;
  asc_tok_t          tok_r;
  logic              active;

  always_ff @(posedge clk) begin
    if (we) begin
      entry_r <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_r <= '0;
    end else begin
      tok_r <= tok_in;
    end
  end

  assign active = MY_ID < IDW'(class_count);

  always_comb begin
    tok_out = tok_r;
    if (tok_r.valid && !tok_r.hit && active && (size <= entry_r)) begin
      tok_out.hit   = 1'b1;
      tok_out.csize = entry_r;
      tok_out.idx   = TOK_IDX_W'(CELL_ID);
    end
  end

endmodule

FILE: rtl/asc_rem_unit.sv
// bit-serial remainder of size by alignment, one dividend bit per cycle
module asc_rem_unit import asc_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [SIZE_W-1:0]  dividend,
  input  logic [ALIGN_W-1:0] divisor,
  output logic               done,
  output logic [ALIGN_W-1:0] rem
);

  localparam int STEP_W = $clog2(SIZE_W);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(SIZE_W - 1);

  logic                run_r, run_nxt;
  logic                done_r, done_nxt;
  logic [STEP_W-1:0]   cnt_r, cnt_nxt;
  logic [SIZE_W-1:0]   dvd_r, dvd_nxt;
  logic [ALIGN_W-1:0]  div_r, div_nxt;
  logic [ALIGN_W-1:0]  rem_r, rem_nxt;
  logic [ALIGN_W:0]    trial;

  always_comb begin
    run_nxt  = run_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    div_nxt  = div_r;
    rem_nxt  = rem_r;
    trial    = {rem_r, dvd_r[SIZE_W-1]};
    if (start) begin
      run_nxt = 1'b1;
      cnt_nxt = '0;
      dvd_nxt = dividend;
      div_nxt = divisor;
      rem_nxt = '0;
    end else if (run_r) begin
      // remainder stays below the divisor, so the trial fits one extra bit
      if (trial >= {1'b0, div_r}) begin
        rem_nxt = ALIGN_W'(trial - {1'b0, div_r});
      end else begin
        rem_nxt = trial[ALIGN_W-1:0];
      end
      dvd_nxt = {dvd_r[SIZE_W-2:0], 1'b0};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == LAST_STEP) begin
        run_nxt  = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      run_r  <= run_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    dvd_r <= dvd_nxt;
    div_r <= div_nxt;
    rem_r <= rem_nxt;
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

FILE: rtl/allocator_size_class_mapper.sv
// top level: apb registers, control, formula classes, table search chain and large-size rounding
//
//  channel | ports                                  | transfer
//  --------+----------------------------------------+--------------------------
//  input   | start, busy, in_*                      | start high and busy low
//  result  | out_valid, out_*                       | out_valid, one cycle only
//  config  | psel penable pwrite paddr pwdata ...   | psel penable pwrite pready
//
//  a table write is registered into its cell and leaves busy low
//  formula lookup: result strobe in the cycle after the transfer
//  table lookup: the token is registered in each of the TABLE_DEPTH cells in turn, then the result strobe
//  large lookup: the remainder unit handles one size bit per cycle, then the result strobe
//  synchronous active-low reset; table entries hold no reset value
//  one item at a time, busy stays high until the result strobe has passed
module allocator_size_class_mapper import asc_pkg::*; #(
  parameter int TABLE_DEPTH = DEFAULT_DEPTH
) (
  input  logic               clk,
  input  logic               rst_n,
  // input channel
  input  logic               start,
  output logic               busy,
  input  logic               in_operation,
  input  logic [SIZE_W-1:0]  in_request_size,
  input  logic [SLOT_W-1:0]  in_entry_index,
  input  logic [SIZE_W-1:0]  in_entry_value,
  // result channel
  output logic               out_valid,
  output logic [1:0]         out_size_category,
  output logic [CSIZE_W-1:0] out_class_size,
  output logic [CIDX_W-1:0]  out_class_index,
  output logic               out_no_class,
  // configuration port
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [APB_AW-1:0]  paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam int WID = TOK_IDX_W + 1;

  // configuration registers
  logic               table_mode_r;
  logic [SIZE_W-1:0]  middle_thr_r;
  logic [SIZE_W-1:0]  large_thr_r;
  logic [ALIGN_W-1:0] large_align_r;
  logic [CNT_W-1:0]   class_count_r;
  logic               cfg_wr;
  logic [2:0]         cfg_idx;

  asc_state_t state_r, state_nxt;

  logic               accept;
  logic               is_lookup;
  logic               in_large;
  logic               wr_en;
  logic [SIZE_W-1:0]  size_r;
  logic [ALIGN_W-1:0] align_eff;

  logic [1:0]         res_cat;
  logic [CSIZE_W-1:0] res_csize_r, res_csize_nxt;
  logic [CIDX_W-1:0]  res_cidx_r, res_cidx_nxt;
  logic               res_miss_r, res_miss_nxt;

  logic [SIZE_W-1:0]  f_sub;
  logic [CIDX_W-1:0]  f_idx;
  logic [CSIZE_W-1:0] f_csize;

  logic               rem_start;
  logic               rem_done;
  logic [ALIGN_W-1:0] rem;
  logic [CSIZE_W-1:0] large_csize;

  asc_tok_t           tok_entry;
  asc_tok_t           chain [0:TABLE_DEPTH];
  asc_tok_t           tok_exit;

  // ---------------- configuration port ----------------
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = paddr[APB_AW-1:3];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      table_mode_r  <= 1'b0;
      middle_thr_r  <= '0;
      large_thr_r   <= LARGE_THR_RST;
      large_align_r <= ALIGN_RST;
      class_count_r <= '0;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_TABLE_MODE:  table_mode_r  <= pwdata[0];
        REG_MIDDLE_THR:  middle_thr_r  <= pwdata[SIZE_W-1:0];
        REG_LARGE_THR:   large_thr_r   <= pwdata[SIZE_W-1:0];
        REG_LARGE_ALIGN: large_align_r <= pwdata[ALIGN_W-1:0];
        REG_CLASS_COUNT: class_count_r <= pwdata[CNT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_idx)
      REG_TABLE_MODE:  prdata = APB_DW'(table_mode_r);
      REG_MIDDLE_THR:  prdata = APB_DW'(middle_thr_r);
      REG_LARGE_THR:   prdata = APB_DW'(large_thr_r);
      REG_LARGE_ALIGN: prdata = APB_DW'(large_align_r);
      REG_CLASS_COUNT: prdata = APB_DW'(class_count_r);
      default:         prdata = '0;
    endcase
  end

  // ---------------- input side ----------------
  assign accept    = start && !busy;
  assign is_lookup = in_operation == OP_LOOKUP;
  assign wr_en     = accept && (in_operation == OP_WRITE);
  assign in_large  = in_request_size > large_thr_r;
  assign align_eff = (large_align_r == '0) ? ALIGN_W'(1) : large_align_r;

  always_ff @(posedge clk) begin
    if (accept && is_lookup) begin
      size_r <= in_request_size;
    end
  end

  // ---------------- control ----------------
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept && is_lookup) begin
          if (in_large) begin
            state_nxt = S_DIV;
          end else if (table_mode_r) begin
            state_nxt = S_CHAIN;
          end else begin
            state_nxt = S_DONE;
          end
        end
      end
      S_CHAIN: begin
        if (tok_exit.valid) begin
          state_nxt = S_DONE;
        end
      end
      S_DIV: begin
        if (rem_done) begin
          state_nxt = S_DONE;
        end
      end
      S_DONE:  state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    busy      = state_r != S_IDLE;
    out_valid = state_r == S_DONE;
    rem_start = accept && is_lookup && in_large;
  end

  // ---------------- formula classes ----------------
  assign f_sub   = in_request_size - FORMULA_BASE;
  assign f_idx   = CIDX_W'(f_sub[SIZE_W-1:FORMULA_SH]) + CIDX_W'(1);
  assign f_csize = CSIZE_W'(FORMULA_BASE) + {f_idx, FORMULA_SH'(0)};

  // ---------------- large sizes ----------------
  asc_rem_unit u_rem (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (rem_start),
    .dividend (in_request_size),
    .divisor  (align_eff),
    .done     (rem_done),
    .rem      (rem)
  );

  // round up: drop the remainder, add a granule only if one was left
  assign large_csize = CSIZE_W'(size_r) - CSIZE_W'(rem)
                     + ((rem != '0) ? CSIZE_W'(align_eff) : CSIZE_W'(0));

  // ---------------- table search chain ----------------
  always_comb begin
    tok_entry       = '0;
    tok_entry.valid = accept && is_lookup && !in_large && table_mode_r;
  end

  assign chain[0] = tok_entry;

  for (genvar i = 0; i < TABLE_DEPTH; i++) begin : g_cell
    logic cell_we;
    assign cell_we = wr_en && (WID'(in_entry_index) == WID'(i));
    asc_cell #(
      .CELL_ID (i)
    ) u_cell (
      .clk         (clk),
      .rst_n       (rst_n),
      .we          (cell_we),
      .wdata       (in_entry_value),
      .size        (size_r),
      .class_count (class_count_r),
      .tok_in      (chain[i]),
      .tok_out     (chain[i+1])
    );
  end

  assign tok_exit = chain[TABLE_DEPTH];

  // ---------------- result ----------------
  always_comb begin
    res_csize_nxt = res_csize_r;
    res_cidx_nxt  = res_cidx_r;
    res_miss_nxt  = res_miss_r;
    case (state_r)
      S_IDLE: begin
        if (accept && is_lookup) begin
          res_miss_nxt = 1'b0;
          if (in_request_size <= FORMULA_BASE) begin
            res_csize_nxt = CSIZE_W'(FORMULA_BASE);
            res_cidx_nxt  = '0;
          end else begin
            res_csize_nxt = f_csize;
            res_cidx_nxt  = f_idx;
          end
        end
      end
      S_CHAIN: begin
        if (tok_exit.valid) begin
          res_miss_nxt  = !tok_exit.hit;
          res_csize_nxt = tok_exit.hit ? CSIZE_W'(tok_exit.csize) : '0;
          res_cidx_nxt  = tok_exit.hit ? CIDX_W'(tok_exit.idx) : '0;
        end
      end
      S_DIV: begin
        if (rem_done) begin
          res_miss_nxt  = 1'b0;
          res_csize_nxt = large_csize;
          res_cidx_nxt  = CIDX_W'(class_count_r);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    res_csize_r <= res_csize_nxt;
    res_cidx_r  <= res_cidx_nxt;
    res_miss_r  <= res_miss_nxt;
  end

  // thresholds must be kept stable while busy (the block does not enforce it); the category follows the held size
  always_comb begin
    if (size_r > large_thr_r) begin
      res_cat = CAT_LARGE;
    end else if ((middle_thr_r != '0) && (middle_thr_r < large_thr_r) &&
                 (size_r >= middle_thr_r)) begin
      res_cat = CAT_MEDIUM;
    end else begin
      res_cat = CAT_SMALL;
    end
  end

  assign out_size_category = res_cat;
  assign out_class_size    = res_csize_r;
  assign out_class_index   = res_cidx_r;
  assign out_no_class      = res_miss_r;

  // ---------------- assertions ----------------
  a_strobe_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid)
    else $error("result strobe longer than one cycle");

  a_chain_exit_in_search: assert property (@(posedge clk) disable iff (!rst_n)
    tok_exit.valid |-> (state_r == S_CHAIN))
    else $error("search token left the chain outside a table lookup");

  a_rem_done_in_div: assert property (@(posedge clk) disable iff (!rst_n)
    rem_done |-> (state_r == S_DIV))
    else $error("remainder finished outside a large lookup");

  a_lookup_goes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (accept && is_lookup) |=> busy)
    else $error("lookup transfer did not make the block busy");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_no_class) |->
      ((out_class_size == '0) && (out_class_index == '0) &&
       (out_size_category != CAT_LARGE)))
    else $error("miss reported with a class or on a large size");

endmodule

FILE: tb/allocator_size_class_mapper_test.sv
`timescale 1ns / 1ps
// testbench for the size class mapper: directed and random lookups checked against a predictor
module allocator_size_class_mapper_test import asc_pkg::*; ();

  localparam int          DEPTH      = DEFAULT_DEPTH;
  localparam logic [63:0] SIZE_MAX   = 64'hFF_FFFF_FFFF;
  localparam logic [63:0] CLASS_BASE = 64'd24;
  localparam logic [63:0] CLASS_STEP = 64'd16;
  localparam logic [63:0] ALIGN_MAX  = 64'd1048576;

  typedef struct packed {
    logic              op;
    logic [SIZE_W-1:0] size;
    logic [SLOT_W-1:0] slot;
    logic [SIZE_W-1:0] value;
  } alloc_req_t;

  typedef struct packed {
    logic [1:0]         category;
    logic [CSIZE_W-1:0] csize;
    logic [CIDX_W-1:0]  cidx;
    logic               miss;
  } class_pick_t;

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               start = 1'b0;
  logic               busy;
  logic               in_operation = OP_LOOKUP;
  logic [SIZE_W-1:0]  in_request_size = '0;
  logic [SLOT_W-1:0]  in_entry_index = '0;
  logic [SIZE_W-1:0]  in_entry_value = '0;
  logic               out_valid;
  logic [1:0]         out_size_category;
  logic [CSIZE_W-1:0] out_class_size;
  logic [CIDX_W-1:0]  out_class_index;
  logic               out_no_class;
  logic               psel = 1'b0;
  logic               penable = 1'b0;
  logic               pwrite = 1'b0;
  logic [APB_AW-1:0]  paddr = '0;
  logic [APB_DW-1:0]  pwdata = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  // predictor copy of the registers and the class table
  logic               mode_q = 1'b0;
  logic [SIZE_W-1:0]  mid_thr = '0;
  logic [SIZE_W-1:0]  big_thr = LARGE_THR_RST;
  logic [ALIGN_W-1:0] align_q = ALIGN_RST;
  logic [CNT_W-1:0]   count_q = '0;
  logic [SIZE_W-1:0]  class_tbl [DEPTH];
  // table as the stimulus will have left it, used to aim lookups
  logic [SIZE_W-1:0]  plan_tbl [DEPTH];

  alloc_req_t  req_q [$];
  class_pick_t pick_q [$];
  bit          offer_live = 1'b0;
  int          gap_pct = 0;
  int          hold_cnt = 0;
  int          err_cnt = 0;

  allocator_size_class_mapper u_top (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_operation      (in_operation),
    .in_request_size   (in_request_size),
    .in_entry_index    (in_entry_index),
    .in_entry_value    (in_entry_value),
    .out_valid         (out_valid),
    .out_size_category (out_size_category),
    .out_class_size    (out_class_size),
    .out_class_index   (out_class_index),
    .out_no_class      (out_no_class),
    .psel              (psel),
    .penable           (penable),
    .pwrite            (pwrite),
    .paddr             (paddr),
    .pwdata            (pwdata),
    .prdata            (prdata),
    .pready            (pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  initial begin
    #12ms;
    $display("allocator_size_class_mapper_test failed");
    $finish;
  end

  function automatic class_pick_t pick_class(logic [SIZE_W-1:0] size);
    class_pick_t r;
    logic [63:0] gran, wide, n;
    r = '0;
    wide = 64'(size);
    if (size > big_thr) begin
      r.category = CAT_LARGE;
    end else if (mid_thr != 0 && mid_thr < big_thr && size >= mid_thr) begin
      r.category = CAT_MEDIUM;
    end else begin
      r.category = CAT_SMALL;
    end
    if (size > big_thr) begin
      // zero alignment behaves as no rounding; a granule is added only on a remainder
      gran = (align_q == 0) ? 64'd1 : 64'(align_q);
      r.csize = CSIZE_W'((wide / gran) * gran + ((wide % gran != 0) ? gran : 64'd0));
      r.cidx = CIDX_W'(count_q);
    end else if (mode_q) begin
      n = (count_q > DEPTH) ? 64'(DEPTH) : 64'(count_q);
      r.miss = 1'b1;
      for (int i = 0; i < n; i++) begin
        if (r.miss && size <= class_tbl[i]) begin
          r.csize = CSIZE_W'(class_tbl[i]);
          r.cidx = CIDX_W'(i);
          r.miss = 1'b0;
        end
      end
    end else if (wide <= CLASS_BASE) begin
      r.csize = CSIZE_W'(CLASS_BASE);
    end else begin
      n = (wide - CLASS_BASE) / CLASS_STEP + 64'd1;
      r.cidx = CIDX_W'(n);
      r.csize = CSIZE_W'(CLASS_BASE + CLASS_STEP * n);
    end
    return r;
  endfunction

  // sender: one item offered at a time, held until transferred
  always @(negedge clk) begin
    alloc_req_t nxt;
    if (!rst_n) begin
      start <= 1'b0;
    end else if (!offer_live) begin
      if (hold_cnt > 0) begin
        hold_cnt--;
        start <= 1'b0;
      end else if (req_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
        nxt = req_q.pop_front();
        in_operation <= nxt.op;
        in_request_size <= nxt.size;
        in_entry_index <= nxt.slot;
        in_entry_value <= nxt.value;
        start <= 1'b1;
        offer_live = 1'b1;
      end else begin
        start <= 1'b0;
        // now and then a long pause so idle cycles land anywhere in a lookup
        if (req_q.size() != 0 && $urandom_range(3) == 0) begin
          hold_cnt = int'($urandom_range(1, DEPTH + 8));
        end
      end
    end
  end

  // results are checked before the transfer of the same edge is predicted
  always @(posedge clk) begin
    class_pick_t want;
    if (rst_n && out_valid) begin
      if (pick_q.size() == 0) begin
        $error("unexpected result: category %0d size %0d index %0d no_class %0d",
               out_size_category, out_class_size, out_class_index, out_no_class);
        err_cnt++;
      end else begin
        want = pick_q.pop_front();
        if (out_size_category !== want.category) begin
          $error("size_category: expected %0d, got %0d", want.category, out_size_category);
          err_cnt++;
        end
        if (out_class_size !== want.csize) begin
          $error("class_size: expected %0d, got %0d", want.csize, out_class_size);
          err_cnt++;
        end
        if (out_class_index !== want.cidx) begin
          $error("class_index: expected %0d, got %0d", want.cidx, out_class_index);
          err_cnt++;
        end
        if (out_no_class !== want.miss) begin
          $error("no_class: expected %0d, got %0d", want.miss, out_no_class);
          err_cnt++;
        end
      end
    end
    if (rst_n && start && !busy) begin
      offer_live = 1'b0;
      if (in_operation == OP_WRITE) begin
        class_tbl[in_entry_index] = in_entry_value;
      end else begin
        pick_q.push_back(pick_class(in_request_size));
      end
    end
  end

  task automatic cfg_write(logic [2:0] reg_id, logic [63:0] val);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {reg_id, 3'b000};
    pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    case (reg_id)
      REG_TABLE_MODE:  mode_q = val[0];
      REG_MIDDLE_THR:  mid_thr = val[SIZE_W-1:0];
      REG_LARGE_THR:   big_thr = val[SIZE_W-1:0];
      REG_LARGE_ALIGN: align_q = val[ALIGN_W-1:0];
      REG_CLASS_COUNT: count_q = val[CNT_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic set_config(logic mode, logic [63:0] mid, logic [63:0] big, logic [63:0] al,
                            logic [63:0] cnt);
    cfg_write(REG_TABLE_MODE, 64'(mode));
    cfg_write(REG_MIDDLE_THR, mid);
    cfg_write(REG_LARGE_THR, big);
    cfg_write(REG_LARGE_ALIGN, al);
    cfg_write(REG_CLASS_COUNT, cnt);
  endtask

  // block goes idle: nothing pending, nothing expected, then the longest latency
  task automatic settle();
    while (req_q.size() != 0 || offer_live || pick_q.size() != 0 || busy) @(posedge clk);
    repeat (DEPTH + 8) @(posedge clk);
  endtask

  task automatic push_item(logic op, logic [63:0] size, logic [63:0] slot, logic [63:0] value);
    alloc_req_t r;
    r.op = op;
    r.size = size[SIZE_W-1:0];
    r.slot = slot[SLOT_W-1:0];
    r.value = value[SIZE_W-1:0];
    if (op == OP_WRITE) plan_tbl[r.slot] = r.value;
    req_q.push_back(r);
  endtask

  task automatic lookup(logic [63:0] size);
    push_item(OP_LOOKUP, size, 64'($urandom), {$urandom, $urandom});
  endtask

  // ascending table; the top entry optionally at the largest size
  task automatic load_table(logic [63:0] step_max, bit top_full);
    logic [63:0] v;
    v = 64'($urandom_range(0, 30));
    for (int i = 0; i < DEPTH; i++) begin
      if (i == DEPTH - 1 && top_full) v = SIZE_MAX;
      push_item(OP_WRITE, 64'd0, 64'(i), v);
      v = v + ({$urandom, $urandom} % step_max) + 64'd1;
    end
  endtask

  function automatic logic [SIZE_W-1:0] pick_size();
    logic [63:0] v;
    case ($urandom_range(0, 9))
      0: v = {$urandom, $urandom};
      1: v = 64'($urandom_range(0, 64));
      2: v = 64'(mid_thr) + 64'($urandom_range(0, 8)) - 64'd4;
      3: v = 64'(big_thr) + 64'($urandom_range(0, 8)) - 64'd4;
      4, 5: v = 64'(plan_tbl[SLOT_W'($urandom_range(0, DEPTH - 1))])
                + 64'($urandom_range(0, 4)) - 64'd2;
      6: v = 64'(big_thr) + 64'($urandom_range(1, 4)) * 64'(align_q)
             + 64'($urandom_range(0, 2)) - 64'd1;
      7: v = 64'($urandom_range(0, 2000));
      8: v = {$urandom, $urandom} % (64'(big_thr) + 64'd1);
      default: v = SIZE_MAX;
    endcase
    return v[SIZE_W-1:0];
  endfunction

  task automatic queue_random(int n);
    logic [SLOT_W-1:0] slot;
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 8) begin
        slot = SLOT_W'($urandom);
        // rewrites mostly stay close to the old entry, sometimes anything
        if ($urandom_range(7) == 0) begin
          push_item(OP_WRITE, {$urandom, $urandom}, 64'(slot), {$urandom, $urandom});
        end else begin
          push_item(OP_WRITE, {$urandom, $urandom}, 64'(slot),
                    64'(plan_tbl[slot]) + 64'($urandom_range(0, 6)) - 64'd3);
        end
      end else begin
        lookup(64'(pick_size()));
      end
    end
  endtask

  task automatic random_config();
    logic        mode;
    logic [63:0] mid, big, al, cnt;
    mode = 1'($urandom_range(0, 1));
    case ($urandom_range(0, 3))
      0: mid = 64'd0;
      1: mid = 64'($urandom_range(1, 5000));
      2: mid = {$urandom, $urandom} & SIZE_MAX;
      default: mid = 64'(plan_tbl[SLOT_W'($urandom_range(0, DEPTH - 1))]);
    endcase
    case ($urandom_range(0, 4))
      0: big = SIZE_MAX;
      1: big = 64'd0;
      2: big = 64'($urandom_range(100, 100000));
      3: big = 64'(plan_tbl[SLOT_W'($urandom_range(0, DEPTH - 1))]);
      default: big = {$urandom, $urandom} & SIZE_MAX;
    endcase
    case ($urandom_range(0, 3))
      0: al = 64'd1;
      1: al = ALIGN_MAX;
      2: al = 64'($urandom_range(1, 32'(ALIGN_MAX)));
      default: al = 64'd1 << $urandom_range(0, 20);
    endcase
    case ($urandom_range(0, 2))
      0: cnt = 64'd0;
      1: cnt = 64'(DEPTH);
      default: cnt = 64'($urandom_range(0, DEPTH));
    endcase
    set_config(mode, mid, big, al, cnt);
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // reset values: formula classes, everything small
    gap_pct = 6;
    lookup(64'd0);
    lookup(64'd1);
    lookup(64'd24);
    lookup(64'd25);
    lookup(64'd40);
    lookup(64'd41);
    lookup(SIZE_MAX);
    queue_random(100);
    load_table(64'd64, 1'b0);
    settle();

    // full table, medium band, no rounding on large sizes
    set_config(1'b1, 64'd100, 64'd5000, 64'd1, 64'(DEPTH));
    lookup(64'd0);
    lookup(64'(plan_tbl[0]));
    lookup(64'(plan_tbl[0]) + 64'd1);
    lookup(64'(plan_tbl[DEPTH - 1]));
    lookup(64'(plan_tbl[DEPTH - 1]) + 64'd1);
    lookup(64'd99);
    lookup(64'd100);
    lookup(64'd5000);
    lookup(64'd5001);
    lookup(SIZE_MAX);
    queue_random(140);
    settle();

    // middle above large: no medium; widest granule, short table
    set_config(1'b1, 64'd300, 64'd200, ALIGN_MAX, 64'd10);
    lookup(64'd200);
    lookup(64'd201);
    lookup(ALIGN_MAX);
    lookup(ALIGN_MAX + 64'd1);
    lookup(SIZE_MAX);
    lookup(64'(plan_tbl[9]));
    lookup(64'(plan_tbl[9]) + 64'd1);
    queue_random(140);
    settle();

    // zero alignment and a zero large threshold
    set_config(1'b0, 64'd1, 64'd0, 64'd0, 64'(DEPTH));
    lookup(64'd0);
    lookup(64'd1);
    queue_random(140);
    settle();

    // no classes in use: every table lookup that is not large misses
    gap_pct = 46;
    set_config(1'b1, SIZE_MAX, SIZE_MAX, 64'(ALIGN_RST), 64'd0);
    queue_random(140);
    settle();

    random_config();
    queue_random(140);
    settle();

    load_table(64'd1 << 34, 1'b1);
    settle();
    random_config();
    queue_random(140);
    settle();

    random_config();
    queue_random(140);
    settle();

    gap_pct = 0;
    for (int p = 0; p < 4; p++) begin
      random_config();
      queue_random(140);
      settle();
    end

    if (err_cnt == 0) begin
      $display("allocator_size_class_mapper_test passed");
    end else begin
      $display("allocator_size_class_mapper_test failed");
    end
    $finish;
  end

endmodule
